// ----- rtl/clip_point_along_direction_into_box_core_macros.svh -----
// Assertion macros for the clip core.
`ifndef CLIP_POINT_ALONG_DIRECTION_INTO_BOX_CORE_MACROS_SVH
`define CLIP_POINT_ALONG_DIRECTION_INTO_BOX_CORE_MACROS_SVH

`define CPB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/cpb_pkg.sv -----
package cpb_pkg;
   localparam int CW    = 32;
   localparam int TW    = 31;
   localparam int QW    = 63;
   localparam int PW    = 2 * CW;
   localparam int DIVW  = PW;
   localparam int NCELL = DIVW;
   localparam logic [TW-1:0] TOL_RESET = TW'(655);

   typedef enum logic [1:0] {
      ST_INSIDE = 2'd0,
      ST_MOVED  = 2'd1,
      ST_WRONG  = 2'd2,
      ST_FAR    = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] px, py, pz;
      logic signed [CW-1:0] dx, dy, dz;
      logic signed [CW-1:0] lx, ly, lz;
      logic signed [CW-1:0] hx, hy, hz;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic signed [CW-1:0] ox, oy, oz;
   } rsp_type;
endpackage

// ----- rtl/cpb_if.sv -----
interface cpb_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/clip_point_along_direction_into_box_core.sv -----
// Each accepted req item passes through stages 1 to 3, the divider cells and stages A to C to rsp.
// Throughput: one item per cycle; the three 64-cell divider chains advance
// in lock step with the pipeline and stall only when rsp is held.
// Reset: synchronous active-high reset clears valid bits and sets tolerance
// to 655 (0.01 in Q16.16).
module clip_point_along_direction_into_box_core
   import cpb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cpb_if.sink   req,
   cpb_if.source rsp,
   cpb_if.sink   csr
);
`include "clip_point_along_direction_into_box_core_macros.svh"
   localparam int NS = 3 + NCELL + 3;

   logic adv;
   logic [NS-1:0] v_ff;
   logic [TW-1:0] tol_ff;
   req_type rq;

   assign rq = req_type'(req.data);
   assign adv = !v_ff[NS-1] || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         tol_ff <= TOL_RESET;
      end else begin
         if (csr.valid) tol_ff <= csr.data[TW-1:0];
         if (adv) v_ff <= {v_ff[NS-2:0], req.valid};
      end
   end

   // stage 1: errors
   logic signed [CW-1:0] p1_ff [3], d1_ff [3], l1_ff [3], h1_ff [3];
   logic signed [CW:0] e1_ff [3];
   logic signed [CW-1:0] pi [3], di [3], li [3], hi_ [3];
   always_comb begin
      pi[0]=rq.px; pi[1]=rq.py; pi[2]=rq.pz;
      di[0]=rq.dx; di[1]=rq.dy; di[2]=rq.dz;
      li[0]=rq.lx; li[1]=rq.ly; li[2]=rq.lz;
      hi_[0]=rq.hx; hi_[1]=rq.hy; hi_[2]=rq.hz;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= pi[i]; d1_ff[i] <= di[i]; l1_ff[i] <= li[i]; h1_ff[i] <= hi_[i];
            if (pi[i] < li[i]) e1_ff[i] <= (CW+1)'(li[i]) - (CW+1)'(pi[i]);
            else if (pi[i] > hi_[i]) e1_ff[i] <= (CW+1)'(hi_[i]) - (CW+1)'(pi[i]);
            else e1_ff[i] <= '0;
         end
      end
   end

   // stage 2: status, magnitudes, cross products
   logic [CW:0] em [3];
   logic [CW-1:0] dm [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         em[i] = e1_ff[i][CW] ? (CW+1)'(-e1_ff[i]) : e1_ff[i];
         dm[i] = d1_ff[i][CW-1] ? CW'(-d1_ff[i]) : d1_ff[i];
      end
   end
   logic [1:0] st2_ff;
   logic [CW:0] em2_ff [3];
   logic [CW-1:0] dm2_ff [3];
   logic signed [CW-1:0] p2_ff [3], d2_ff [3], l2_ff [3], h2_ff [3];
   logic [2*CW:0] x01_ff, x10_ff, x02_ff, x20_ff, x12_ff, x21_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic ins, wr;
         ins = 1'b1; wr = 1'b0;
         for (int i = 0; i < 3; i++) begin
            if (e1_ff[i] != 0) begin
               ins = 1'b0;
               if (d1_ff[i] == 0 || (d1_ff[i][CW-1] != e1_ff[i][CW])) wr = 1'b1;
            end
         end
         st2_ff <= ins ? ST_INSIDE : (wr ? ST_WRONG : ST_MOVED);
         em2_ff <= em; dm2_ff <= dm;
         p2_ff <= p1_ff; d2_ff <= d1_ff; l2_ff <= l1_ff; h2_ff <= h1_ff;
         x01_ff <= em[0]*dm[1]; x10_ff <= em[1]*dm[0];
         x02_ff <= em[0]*dm[2]; x20_ff <= em[2]*dm[0];
         x12_ff <= em[1]*dm[2]; x21_ff <= em[2]*dm[1];
      end
   end

   // stage 3: pick axis, form numerators
   logic [1:0] k;
   always_comb begin
      logic [1:0] kk;
      kk = 2'd3;
      if (em2_ff[0] != 0) kk = 2'd0;
      if (em2_ff[1] != 0 && (kk == 2'd3 || x10_ff > x01_ff)) kk = 2'd1;
      if (em2_ff[2] != 0) begin
         if (kk == 2'd3) kk = 2'd2;
         else if (kk == 2'd0 && x20_ff > x02_ff) kk = 2'd2;
         else if (kk == 2'd1 && x21_ff > x12_ff) kk = 2'd2;
      end
      k = (kk == 2'd3) ? 2'd0 : kk;
   end
   logic [PW-1:0] n3_ff [3];
   logic [DIVW-1:0] dc_ff [NCELL+1];
   logic [1:0] sc_ff [NCELL+1];
   logic signed [CW-1:0] pc_ff [NCELL+1][3], dd_ff [NCELL+1][3];
   logic signed [CW-1:0] lc_ff [NCELL+1][3], hc_ff [NCELL+1][3];
   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff[0] <= st2_ff;
         dc_ff[0] <= DIVW'(dm2_ff[k]);
         pc_ff[0] <= p2_ff; dd_ff[0] <= d2_ff; lc_ff[0] <= l2_ff; hc_ff[0] <= h2_ff;
         for (int i = 0; i < 3; i++) n3_ff[i] <= PW'(dm2_ff[i]) * PW'(em2_ff[k]);
      end
   end

   // divider chains: one quotient bit per cell
   logic [DIVW:0] rc [3][NCELL];
   logic [PW-1:0] nc [3][NCELL];
   logic [NCELL-1:0] qc [3][NCELL];
   for (genvar c = 0; c < NCELL; c++) begin : g_cell
      for (genvar a = 0; a < 3; a++) begin : g_ax
         logic [DIVW:0] r_c;
         logic [PW-1:0] n_c;
         logic [NCELL-1:0] q_c;
         if (c == 0) begin : g_head
            assign r_c = '0;
            assign n_c = n3_ff[a];
            assign q_c = '0;
         end else begin : g_link
            assign r_c = rc[a][c-1];
            assign n_c = nc[a][c-1];
            assign q_c = qc[a][c-1];
         end
         cpb_cell u_cell (
            .clock(clock), .en(adv), .r_i(r_c), .n_i(n_c), .q_i(q_c),
            .den(dc_ff[c]), .r_o(rc[a][c]), .n_o(nc[a][c]), .q_o(qc[a][c]));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dc_ff[c+1] <= dc_ff[c]; sc_ff[c+1] <= sc_ff[c];
            pc_ff[c+1] <= pc_ff[c]; dd_ff[c+1] <= dd_ff[c];
            lc_ff[c+1] <= lc_ff[c]; hc_ff[c+1] <= hc_ff[c];
         end
      end
   end

   // stage A: round, saturate, move
   localparam logic [QW:0] CAP = (QW+1)'(1) << 62;
   localparam logic signed [QW+1:0] R_MAX = {{(QW+3-CW){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [QW+1:0] R_MIN = {{(QW+3-CW){1'b1}}, {(CW-1){1'b0}}};
   logic [1:0] sa_ff;
   logic signed [CW-1:0] pa_ff [3], ma_ff [3], la_ff [3], ha_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff <= sc_ff[NCELL];
         pa_ff <= pc_ff[NCELL]; la_ff <= lc_ff[NCELL]; ha_ff <= hc_ff[NCELL];
         for (int a = 0; a < 3; a++) begin
            logic [QW:0] q;
            logic signed [QW+1:0] r;
            q = qc[a][NCELL-1];
            if (q >= CAP) q = CAP;
            else if ({rc[a][NCELL-1], 1'b0} >= {2'b0, dc_ff[NCELL]}) q = q + 1'b1;
            if (q > CAP) q = CAP;
            r = dd_ff[NCELL][a][CW-1] ? (QW+2)'(pc_ff[NCELL][a]) - $signed({1'b0, q})
                                       : (QW+2)'(pc_ff[NCELL][a]) + $signed({1'b0, q});
            if (r > R_MAX) ma_ff[a] <= R_MAX[CW-1:0];
            else if (r < R_MIN) ma_ff[a] <= R_MIN[CW-1:0];
            else ma_ff[a] <= r[CW-1:0];
         end
      end
   end

   // stage B: distance terms
   logic [1:0] sb_ff;
   logic signed [CW-1:0] pb_ff [3], mb_ff [3];
   logic far_b_ff;
   logic [2*CW-1:0] sq_ff [3];
   logic [2*TW-1:0] tsq_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic far;
         far = 1'b0;
         sb_ff <= sa_ff; pb_ff <= pa_ff; mb_ff <= ma_ff;
         tsq_ff <= tol_ff * tol_ff;
         for (int a = 0; a < 3; a++) begin
            logic signed [CW:0] e;
            logic [CW:0] m;
            logic [2*TW-1:0] sq;
            if (ma_ff[a] < la_ff[a]) e = (CW+1)'(la_ff[a]) - (CW+1)'(ma_ff[a]);
            else if (ma_ff[a] > ha_ff[a]) e = (CW+1)'(ma_ff[a]) - (CW+1)'(ha_ff[a]);
            else e = '0;
            m = e[CW] ? (CW+1)'(-e) : e;
            sq = m[30:0] * m[30:0];
            if (m >= (CW+1)'(64'h8000_0000)) begin
               far = 1'b1; sq_ff[a] <= '0;
            end else sq_ff[a] <= (2*CW)'(sq);
         end
         far_b_ff <= far;
      end
   end

   // stage C: decide
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [2*CW+1:0] s;
         rsp_type o;
         s = (2*CW+2)'(sq_ff[0]) + (2*CW+2)'(sq_ff[1]) + (2*CW+2)'(sq_ff[2]);
         o.ox = pb_ff[0]; o.oy = pb_ff[1]; o.oz = pb_ff[2];
         o.status = sb_ff;
         if (sb_ff == ST_MOVED) begin
            if (far_b_ff || s > (2*CW+2)'(tsq_ff)) o.status = ST_FAR;
            else begin
               o.ox = mb_ff[0]; o.oy = mb_ff[1]; o.oz = mb_ff[2];
            end
         end
         out_ff <= o;
      end
   end
   assign rsp.valid = v_ff[NS-1];
   assign rsp.data = out_ff;

   `CPB_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `CPB_ASSERT_IMP(a_rdy, clock, reset, !rsp.valid, req.ready)
   `CPB_ASSERT_NEXT(a_tol, clock, reset, csr.valid, tol_ff == $past(csr.data[TW-1:0]))
endmodule

// ----- rtl/cpb_cell.sv -----
module cpb_cell
   import cpb_pkg::*;
(
   input  logic clock,
   input  logic en,
   input  logic [DIVW:0] r_i,
   input  logic [PW-1:0] n_i,
   input  logic [NCELL-1:0] q_i,
   input  logic [DIVW-1:0] den,
   output logic [DIVW:0] r_o,
   output logic [PW-1:0] n_o,
   output logic [NCELL-1:0] q_o
);
   logic [DIVW+1:0] sh;
   logic [DIVW+1:0] df;
   assign sh = {r_i, n_i[PW-1]};
   assign df = sh - {2'b0, den};
   always_ff @(posedge clock) begin
      if (en) begin
         n_o <= {n_i[PW-2:0], 1'b0};
         if (!df[DIVW+1]) begin
            r_o <= df[DIVW:0];
            q_o <= {q_i[NCELL-2:0], 1'b1};
         end else begin
            r_o <= sh[DIVW:0];
            q_o <= {q_i[NCELL-2:0], 1'b0};
         end
      end
   end
endmodule
